[rtl/egt_pkg.sv]
// Package for the exposure and gamma tone mapper: beat and register types,
// register indexes and reset values, and the elaborated table of root factors.
// It depends on nothing and is used by every module under rtl.
package egt_pkg;

   localparam int LANES       = 3;
   localparam int ROOT_STAGES = 32;

   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7653;

   localparam logic [3:0] CSR_EXPOSURE_GAIN     = 4'd0;
   localparam logic [3:0] CSR_INVERSE_GAMMA     = 4'd1;
   localparam logic [3:0] CSR_ACCUMULATE_ENABLE = 4'd2;
   localparam logic [3:0] CSR_SAMPLE_COUNT      = 4'd3;

   localparam logic [15:0] EXPOSURE_GAIN_RESET = 16'd256;
   localparam logic [15:0] INVERSE_GAMMA_RESET = 16'd1862;
   localparam logic [15:0] SAMPLE_COUNT_RESET  = 16'd1;

   typedef struct packed {
      logic [31:0] red_in;
      logic [31:0] green_in;
      logic [31:0] blue_in;
   } req_data_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] exposure_gain;
      logic [15:0] inverse_gamma;
      logic        accumulate_enable;
      logic [15:0] sample_count;
   } cfg_type;

   typedef logic [ROOT_STAGES-1:0][31:0] root_rom_type;

   function automatic logic [63:0] isqrt64(logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = 64'd0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > v) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic root_rom_type build_root_rom();
      root_rom_type rom;
      logic [63:0]  x;
      x = isqrt64(64'h8000_0000_0000_0000);
      rom[0] = x[31:0];
      for (int j = 1; j < ROOT_STAGES; j++) begin
         x = isqrt64({x[31:0], 32'd0});
         rom[j] = x[31:0];
      end
      return rom;
   endfunction

   localparam root_rom_type ROOT_ROM = build_root_rom();

endpackage

[rtl/egt_csr.sv]
// Configuration registers of the tone mapper, written one beat at a time.
// Uses egt_pkg for the register indexes, reset values and cfg_type.
module egt_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output egt_pkg::cfg_type  cfg
);

   egt_pkg::cfg_type cfg_ff;
   egt_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            egt_pkg::CSR_EXPOSURE_GAIN:     cfg_in.exposure_gain     = csr_wdata;
            egt_pkg::CSR_INVERSE_GAMMA:     cfg_in.inverse_gamma     = csr_wdata;
            egt_pkg::CSR_ACCUMULATE_ENABLE: cfg_in.accumulate_enable = csr_wdata[0];
            egt_pkg::CSR_SAMPLE_COUNT:      cfg_in.sample_count      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exposure_gain     <= egt_pkg::EXPOSURE_GAIN_RESET;
         cfg_ff.inverse_gamma     <= egt_pkg::INVERSE_GAMMA_RESET;
         cfg_ff.accumulate_enable <= 1'b0;
         cfg_ff.sample_count      <= egt_pkg::SAMPLE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/egt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for the three lanes.
// Uses egt_pkg for the lane count.
module egt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_dividend [egt_pkg::LANES],
   input  logic [15:0] divisor,
   output logic        out_valid,
   output logic [31:0] out_quotient [egt_pkg::LANES]
);

   localparam int STAGES = 32;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [31:0]       w_ff   [STAGES][egt_pkg::LANES];
   logic [31:0]       w_in   [STAGES][egt_pkg::LANES];
   logic [15:0]       rem_ff [STAGES][egt_pkg::LANES];
   logic [15:0]       rem_in [STAGES][egt_pkg::LANES];

   function automatic logic [47:0] div_step(logic [15:0] rem, logic [31:0] w,
                                            logic [15:0] n);
      logic [16:0] trial;
      logic        ge;
      logic [15:0] rem_n;
      trial = {rem, w[31]};
      ge    = trial >= {1'b0, n};
      rem_n = ge ? 16'(trial - {1'b0, n}) : trial[15:0];
      return {rem_n, w[30:0], ge};
   endfunction

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], in_valid};
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         {rem_in[0][c], w_in[0][c]} = div_step(16'd0, in_dividend[c], divisor);
      end
      for (int d = 1; d < STAGES; d++) begin
         for (int c = 0; c < egt_pkg::LANES; c++) begin
            {rem_in[d][c], w_in[d][c]} = div_step(rem_ff[d-1][c], w_ff[d-1][c], divisor);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= w_in;
         rem_ff <= rem_in;
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_quotient = w_ff[STAGES-1];

endmodule

[rtl/egt_exp2.sv]
// Pipelined power of two 2^-(k + f) in Q1.32: one root factor multiply per
// stage, then the integer shift. Uses egt_pkg for the lane count and root table.
module egt_exp2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic        in_kill [egt_pkg::LANES],
   input  logic [4:0]  in_k    [egt_pkg::LANES],
   input  logic [31:0] in_f    [egt_pkg::LANES],
   output logic        out_valid,
   output logic [32:0] out_value [egt_pkg::LANES]
);

   localparam int STAGES = egt_pkg::ROOT_STAGES;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [32:0]       m_ff    [STAGES][egt_pkg::LANES];
   logic [32:0]       m_in    [STAGES][egt_pkg::LANES];
   logic [31:0]       f_ff    [STAGES][egt_pkg::LANES];
   logic [4:0]        k_ff    [STAGES][egt_pkg::LANES];
   logic              kill_ff [STAGES][egt_pkg::LANES];
   logic              out_valid_ff;
   logic [32:0]       value_ff [egt_pkg::LANES];
   logic [32:0]       value_in [egt_pkg::LANES];

   function automatic logic [32:0] exp_step(logic [32:0] m, logic [31:0] root);
      logic [64:0] prod;
      prod = {32'd0, m} * {33'd0, root} + (65'd1 << 31);
      return prod[64:32];
   endfunction

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], in_valid};
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         m_in[0][c] = in_f[c][31] ? exp_step(egt_pkg::ONE_Q32, egt_pkg::ROOT_ROM[0])
                                  : egt_pkg::ONE_Q32;
      end
      for (int j = 1; j < STAGES; j++) begin
         for (int c = 0; c < egt_pkg::LANES; c++) begin
            m_in[j][c] = f_ff[j-1][c][5'(STAGES-1-j)]
                       ? exp_step(m_ff[j-1][c], egt_pkg::ROOT_ROM[j]) : m_ff[j-1][c];
         end
      end
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         value_in[c] = kill_ff[STAGES-1][c] ? 33'd0
                                             : (m_ff[STAGES-1][c] >> k_ff[STAGES-1][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= m_in;
         value_ff <= value_in;
         f_ff[0]    <= in_f;
         k_ff[0]    <= in_k;
         kill_ff[0] <= in_kill;
         for (int j = 1; j < STAGES; j++) begin
            f_ff[j]    <= f_ff[j-1];
            k_ff[j]    <= k_ff[j-1];
            kill_ff[j] <= kill_ff[j-1];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = value_ff;

`ifndef SYNTHESIS
   a_mantissa_bounded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] |-> (!m_ff[STAGES-1][0][32] || (m_ff[STAGES-1][0][31:0] == 32'd0)))
      else $error("Mantissa product has grown above one.");
`endif

endmodule

[rtl/egt_log2.sv]
// Pipelined -log2(t) for t in Q1.32: a normalising stage, one squaring per
// stage for the mantissa bits, then the final subtract. Uses egt_pkg for lanes.
module egt_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [32:0] in_t [egt_pkg::LANES],
   output logic        out_valid,
   output logic        out_zero [egt_pkg::LANES],
   output logic [37:0] out_q    [egt_pkg::LANES]
);

   localparam int STAGES = 33;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [31:0]       x_ff    [STAGES][egt_pkg::LANES];
   logic [31:0]       x_in    [STAGES][egt_pkg::LANES];
   logic [31:0]       frac_ff [STAGES][egt_pkg::LANES];
   logic [31:0]       frac_in [STAGES][egt_pkg::LANES];
   logic [4:0]        lz_ff   [STAGES][egt_pkg::LANES];
   logic [4:0]        lz_in   [egt_pkg::LANES];
   logic              one_ff  [STAGES][egt_pkg::LANES];
   logic              zero_ff [STAGES][egt_pkg::LANES];
   logic              out_valid_ff;
   logic              out_zero_ff [egt_pkg::LANES];
   logic [37:0]       q_ff [egt_pkg::LANES];
   logic [37:0]       q_in [egt_pkg::LANES];

   function automatic logic [4:0] lead_zeros(logic [31:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 5'(31 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [32:0] sq_step(logic [31:0] x);
      logic [63:0] sq;
      logic [32:0] s;
      sq = {32'd0, x} * {32'd0, x};
      s  = sq[63:31];
      return s[32] ? {1'b1, s[32:1]} : {1'b0, s[31:0]};
   endfunction

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], in_valid};
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         lz_in[c]      = lead_zeros(in_t[c][31:0]);
         x_in[0][c]    = in_t[c][31:0] << lz_in[c];
         frac_in[0][c] = 32'd0;
      end
      for (int j = 1; j < STAGES; j++) begin
         for (int c = 0; c < egt_pkg::LANES; c++) begin
            {frac_in[j][c][0], x_in[j][c]} = sq_step(x_ff[j-1][c]);
            frac_in[j][c][31:1] = frac_ff[j-1][c][30:0];
         end
      end
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         q_in[c] = one_ff[STAGES-1][c] ? 38'd0
                 : ({6'({1'b0, lz_ff[STAGES-1][c]} + 6'd1), 32'd0}
                    - {6'd0, frac_ff[STAGES-1][c]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         frac_ff <= frac_in;
         q_ff    <= q_in;
         out_zero_ff <= zero_ff[STAGES-1];
         for (int c = 0; c < egt_pkg::LANES; c++) begin
            lz_ff[0][c]   <= lz_in[c];
            one_ff[0][c]  <= in_t[c][32];
            zero_ff[0][c] <= (in_t[c] == 33'd0);
         end
         for (int j = 1; j < STAGES; j++) begin
            lz_ff[j]   <= lz_ff[j-1];
            one_ff[j]  <= one_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_zero  = out_zero_ff;
   assign out_q     = q_ff;

`ifndef SYNTHESIS
   a_mantissa_normalised: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES-1] && !zero_ff[STAGES-1][0] && !one_ff[STAGES-1][0])
      |-> x_ff[STAGES-1][0][31])
      else $error("Log mantissa has lost its leading one.");
`endif

endmodule

[rtl/exposure_gamma_tonemap.sv]
// Top level of the exposure and gamma tone mapper for RGB pixels.
// Depends on egt_pkg, egt_csr, egt_div, egt_exp2 and egt_log2.
//
// Pixels arrive as req_data beats (Q16.16 red, green, blue) under req_valid and
// req_stall, and leave as rsp_data beats (Q0.16) under rsp_valid and rsp_stall.
// Every pixel gives exactly one result, in order. Each channel passes through a
// 32 stage divider, the exposure multiplies, a 33 stage power of two, a 34 stage
// logarithm, the gamma multiply, a second power of two and the output rounding.
// One pixel enters per cycle while the output is not stalled; the divider and
// the two chains of root factor multiplies are fully pipelined, one stage per
// multiply. Registers are written on the csr channel, which is always ready;
// writes are to be made by the user only while no pixel is in flight; the block
// does not enforce this. Reset clears every valid bit and returns the registers
// to their reset values. When the receiver stalls a waiting result, the whole
// pipeline holds and req_stall rises, so nothing is lost or repeated.
module exposure_gamma_tonemap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  egt_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output egt_pkg::rsp_data_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   egt_pkg::cfg_type cfg;
   logic             en;
   logic [15:0]      divisor;

   logic [31:0] chan   [egt_pkg::LANES];
   logic        div_valid;
   logic [31:0] quot   [egt_pkg::LANES];

   logic        m1_valid_ff;
   logic [47:0] p_ff   [egt_pkg::LANES];
   logic        m2_valid_ff;
   logic        a_kill_ff [egt_pkg::LANES];
   logic [4:0]  a_k_ff    [egt_pkg::LANES];
   logic [31:0] a_f_ff    [egt_pkg::LANES];
   logic        e_valid;
   logic [32:0] e_value [egt_pkg::LANES];
   logic        t_valid_ff;
   logic [32:0] t_ff    [egt_pkg::LANES];
   logic        q_valid;
   logic        q_zero  [egt_pkg::LANES];
   logic [37:0] q_value [egt_pkg::LANES];
   logic        r_valid_ff;
   logic        r_kill_ff [egt_pkg::LANES];
   logic [4:0]  r_k_ff    [egt_pkg::LANES];
   logic [31:0] r_f_ff    [egt_pkg::LANES];
   logic        y_valid;
   logic [32:0] y_value [egt_pkg::LANES];
   logic        rsp_valid_ff;
   logic [15:0] out_ff [egt_pkg::LANES];
   logic [15:0] out_in [egt_pkg::LANES];

   logic        a_kill_in [egt_pkg::LANES];
   logic [37:0] a_in      [egt_pkg::LANES];
   logic        r_kill_in [egt_pkg::LANES];
   logic [41:0] r_in      [egt_pkg::LANES];

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   assign divisor = !cfg.accumulate_enable ? 16'd1
                  : (cfg.sample_count == 16'd0) ? 16'd1 : cfg.sample_count;

   assign chan[0] = req_data.red_in;
   assign chan[1] = req_data.green_in;
   assign chan[2] = req_data.blue_in;

   egt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   egt_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .in_dividend  (chan),
      .divisor      (divisor),
      .out_valid    (div_valid),
      .out_quotient (quot)
   );

   always_comb begin
      logic [61:0] ap;
      logic [53:0] rp;
      logic [33:0] yr;
      ap = 62'd0;
      rp = 54'd0;
      yr = 34'd0;
      for (int c = 0; c < egt_pkg::LANES; c++) begin
         ap = {33'd0, p_ff[c][28:0]} * {29'd0, egt_pkg::LOG2E_Q32} + (62'd1 << 23);
         a_in[c]      = ap[61:24];
         a_kill_in[c] = (|p_ff[c][47:29]) || a_in[c][37];
         rp = {16'd0, q_value[c]} * {38'd0, cfg.inverse_gamma} + 54'd2048;
         r_in[c]      = rp[53:12];
         r_kill_in[c] = q_zero[c] || (|r_in[c][41:37]);
         yr = {1'b0, y_value[c]} + 34'h0_0000_8000;
         if (cfg.inverse_gamma == 16'd0 || (|yr[33:32])) begin
            out_in[c] = 16'hFFFF;
         end else begin
            out_in[c] = yr[31:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < egt_pkg::LANES; c++) begin
            p_ff[c]      <= {16'd0, quot[c]} * {32'd0, cfg.exposure_gain};
            a_kill_ff[c] <= a_kill_in[c];
            a_k_ff[c]    <= a_in[c][36:32];
            a_f_ff[c]    <= a_in[c][31:0];
            t_ff[c]      <= egt_pkg::ONE_Q32 - e_value[c];
            r_kill_ff[c] <= r_kill_in[c];
            r_k_ff[c]    <= r_in[c][36:32];
            r_f_ff[c]    <= r_in[c][31:0];
            out_ff[c]    <= out_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         t_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff  <= div_valid;
         m2_valid_ff  <= m1_valid_ff;
         t_valid_ff   <= e_valid;
         r_valid_ff   <= q_valid;
         rsp_valid_ff <= y_valid;
      end
   end

   egt_exp2 u_exposure_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m2_valid_ff),
      .in_kill   (a_kill_ff),
      .in_k      (a_k_ff),
      .in_f      (a_f_ff),
      .out_valid (e_valid),
      .out_value (e_value)
   );

   egt_log2 u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t_valid_ff),
      .in_t      (t_ff),
      .out_valid (q_valid),
      .out_zero  (q_zero),
      .out_q     (q_value)
   );

   egt_exp2 u_gamma_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid_ff),
      .in_kill   (r_kill_ff),
      .in_k      (r_k_ff),
      .in_f      (r_f_ff),
      .out_valid (y_valid),
      .out_value (y_value)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.red_out   = out_ff[0];
   assign rsp_data.green_out = out_ff[1];
   assign rsp_data.blue_out  = out_ff[2];

`ifndef SYNTHESIS
   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat offered straight after reset.");
`endif

endmodule

[tb/exposure_gamma_tonemap_tb.sv]
// Self-checking testbench for the exposure and gamma tone mapper.
// Drives pixel beats against a bit-exact fixed point predictor and checks every result.
// Depends on egt_pkg and the exposure_gamma_tonemap top level.
module exposure_gamma_tonemap_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 137;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [3:0] CSR_UNUSED_INDEX = 4'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   egt_pkg::req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   egt_pkg::rsp_data_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = egt_pkg::CSR_EXPOSURE_GAIN;
   logic [15:0] csr_wdata = '0;

   exposure_gamma_tonemap DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [15:0] gain_q = egt_pkg::EXPOSURE_GAIN_RESET;
   logic [15:0] gamma_q = egt_pkg::INVERSE_GAMMA_RESET;
   logic accum_q = 1'b0;
   logic [15:0] count_q = egt_pkg::SAMPLE_COUNT_RESET;
   logic [63:0] root_factor [32];
   egt_pkg::rsp_data_type pending_pixels [$];
   int errors = 0;
   longint cycles = 0;
   bit hold_off = 1'b0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] pow2_neg(logic [63:0] a);
      logic [63:0] m;
      m = 64'h1_0000_0000;
      if ((a >> 32) >= 32) return 0;
      for (int j = 0; j < 32; j++)
         if (a[31-j]) m = (m * root_factor[j] + 64'h8000_0000) >> 32;
      return m >> a[63:32];
   endfunction

   function automatic logic [63:0] log2_neg_q(logic [63:0] t);
      logic [63:0] x, frac, lz;
      x = t;
      frac = 0;
      lz = 0;
      if (t >= 64'h1_0000_0000) return 0;
      while (x < 64'h8000_0000) begin
         x = x << 1;
         lz++;
      end
      for (int i = 0; i < 32; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= 64'h1_0000_0000) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      return ((lz + 1) << 32) - frac;
   endfunction

   function automatic logic [15:0] tonemap_channel(logic [31:0] chan);
      logic [63:0] v, p, e, t, q, r, y, o, a;
      v = chan;
      if (accum_q) v = v / ((count_q == 0) ? 64'd1 : 64'(count_q));
      if (gamma_q == 0) return 16'hFFFF;
      p = v * gain_q;
      if (p >= (64'd32 << 24)) begin
         e = 0;
      end else begin
         a = (p * 64'h1_7154_7653 + (64'd1 << 23)) >> 24;
         e = pow2_neg(a);
      end
      t = 64'h1_0000_0000 - e;
      if (t == 0) return 16'd0;
      q = log2_neg_q(t);
      r = (q * gamma_q + (64'd1 << 11)) >> 12;
      y = pow2_neg(r);
      o = (y + (64'd1 << 15)) >> 16;
      return (o > 64'hFFFF) ? 16'hFFFF : o[15:0];
   endfunction

   function automatic egt_pkg::rsp_data_type tonemap_pixel(egt_pkg::req_data_type px);
      egt_pkg::rsp_data_type res;
      res.red_out = tonemap_channel(px.red_in);
      res.green_out = tonemap_channel(px.green_in);
      res.blue_out = tonemap_channel(px.blue_in);
      return res;
   endfunction

   task automatic write_csr(logic [3:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         egt_pkg::CSR_EXPOSURE_GAIN: gain_q = val;
         egt_pkg::CSR_INVERSE_GAMMA: gamma_q = val;
         egt_pkg::CSR_ACCUMULATE_ENABLE: accum_q = val[0];
         egt_pkg::CSR_SAMPLE_COUNT: count_q = val;
         default: ;
      endcase
   endtask

   task automatic send_pixel(egt_pkg::req_data_type px, bit fixed_known,
                             egt_pkg::rsp_data_type fixed_res);
      req_data <= px;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(fixed_known ? fixed_res : tonemap_pixel(px));
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_chan();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0001_FFFF);
         2: return $urandom_range(0, 32'h0000_0FFF);
         3: return 32'h0010_0000 >> $urandom_range(0, 20);
         default: return $urandom_range(0, 32'h000F_FFFF);
      endcase
   endfunction

   typedef struct {
      egt_pkg::req_data_type px;
      bit known;
      egt_pkg::rsp_data_type res;
   } stim_row;

   always @(posedge clock) begin
      egt_pkg::rsp_data_type exp_px;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("exposure_gamma_tonemap test failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_data.red_out !== exp_px.red_out) begin
               $error("red_out expected %0d actual %0d", exp_px.red_out, rsp_data.red_out);
               errors++;
            end
            if (rsp_data.green_out !== exp_px.green_out) begin
               $error("green_out expected %0d actual %0d", exp_px.green_out,
                      rsp_data.green_out);
               errors++;
            end
            if (rsp_data.blue_out !== exp_px.blue_out) begin
               $error("blue_out expected %0d actual %0d", exp_px.blue_out, rsp_data.blue_out);
               errors++;
            end
         end
      end
   end

   // The receiver stalls on a pattern of its own, with one long hold-off.
   initial begin
      int phase;
      int held;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            held = 0;
            while (held < 400) begin
               @(posedge clock);
               held++;
            end
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            phase = (phase + 1) % 300;
            if (phase < 100) rsp_stall <= 1'b0;
            else rsp_stall <= ($urandom_range(0, 2) == 0);
         end
      end
   end

   initial begin
      stim_row rows [$];
      egt_pkg::req_data_type px;
      egt_pkg::rsp_data_type sat;
      logic [15:0] gains [6];
      logic [15:0] gammas [5];
      sat = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      gains = '{16'd0, 16'd1, 16'd256, 16'd4096, 16'hFFFF, 16'd64};
      gammas = '{16'd1862, 16'd0, 16'd1, 16'd4096, 16'hFFFF};
      root_factor[0] = int_sqrt(64'h8000_0000_0000_0000);
      for (int j = 1; j < 32; j++) root_factor[j] = int_sqrt(root_factor[j-1] << 32);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset settings; zero input and full scale are read off directly.
      rows.push_back('{'{32'd0, 32'd0, 32'd0}, 1'b1, '{16'd0, 16'd0, 16'd0}});
      rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, sat});
      rows.push_back('{'{32'h0001_0000, 32'h0000_8000, 32'h0000_0001}, 1'b0, '0});
      rows.push_back('{'{32'h0020_0000, 32'h001F_FFFF, 32'h0000_0000}, 1'b0, '0});
      rows.push_back('{'{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF}, 1'b0, '0});
      foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].res);
      drain();

      // Zero inverse gamma saturates every channel.
      write_csr(egt_pkg::CSR_INVERSE_GAMMA, 16'd0);
      send_pixel('{32'd0, 32'h1234_5678, 32'hFFFF_FFFF}, 1'b1, sat);
      drain();
      write_csr(egt_pkg::CSR_INVERSE_GAMMA, egt_pkg::INVERSE_GAMMA_RESET);
      // Accumulation with a zero count behaves as a count of one.
      write_csr(egt_pkg::CSR_ACCUMULATE_ENABLE, 16'd1);
      write_csr(egt_pkg::CSR_SAMPLE_COUNT, 16'd0);
      send_pixel('{32'h0001_0000, 32'd0, 32'h0000_4000}, 1'b0, '0);
      drain();
      write_csr(CSR_UNUSED_INDEX, 16'h0BAD);
      write_csr(egt_pkg::CSR_SAMPLE_COUNT, 16'hFFFF);
      send_pixel('{32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_FFFF}, 1'b0, '0);
      drain();
      write_csr(egt_pkg::CSR_ACCUMULATE_ENABLE, 16'd0);
      write_csr(egt_pkg::CSR_SAMPLE_COUNT, 16'd7);
      send_pixel('{32'h0003_0000, 32'h0000_1000, 32'h0008_0000}, 1'b0, '0);
      drain();

      // Long hold-off while pixels keep coming, to fill the pipeline.
      hold_off = 1'b1;
      for (int i = 0; i < 200; i++) begin
         px = '{rand_chan(), rand_chan(), rand_chan()};
         send_pixel(px, 1'b0, '0);
      end
      drain();

      for (int phase_i = 0; phase_i < 10; phase_i++) begin
         write_csr(egt_pkg::CSR_EXPOSURE_GAIN,
                   (phase_i < 6) ? gains[phase_i] : 16'($urandom));
         write_csr(egt_pkg::CSR_INVERSE_GAMMA, (phase_i < 5) ? gammas[phase_i]
                                                    : 16'($urandom_range(500, 8192)));
         write_csr(egt_pkg::CSR_ACCUMULATE_ENABLE, 16'(phase_i % 2));
         write_csr(egt_pkg::CSR_SAMPLE_COUNT,
                   (phase_i == 3) ? 16'd0 : 16'($urandom_range(0, 300)));
         for (int i = 0; i < 95; i++) begin
            px = '{rand_chan(), rand_chan(), rand_chan()};
            send_pixel(px, 1'b0, '0);
            if ($urandom_range(0, 9) == 0) idle_gap();
         end
         drain();
      end

      if (errors == 0) begin
         $display("exposure_gamma_tonemap test passed");
      end else begin
         $display("exposure_gamma_tonemap test failed");
      end
      $finish;
   end
endmodule

[files.f]
rtl/egt_pkg.sv
rtl/egt_csr.sv
rtl/egt_div.sv
rtl/egt_exp2.sv
rtl/egt_log2.sv
rtl/exposure_gamma_tonemap.sv
tb/exposure_gamma_tonemap_tb.sv
